>>> rtl/core/lbpe_pkg.sv
// ----------------------------------------------------------------------------
// lbpe_pkg
// Shared types and constants for the block-interior LBP encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lbpe_pkg;

    // Field widths
    localparam int unsigned PIXEL_W   = 8;
    localparam int unsigned CODE_W    = 8;
    localparam int unsigned COORD_W   = 10;
    localparam int unsigned CFG_W     = 11;
    localparam int unsigned PHASE_W   = 10;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // Register map, decoded on paddr[2]
    localparam int unsigned REG_SEL_BIT     = 2;
    localparam logic        REG_IMAGE_WIDTH = 1'b0;
    localparam logic        REG_TILE_SIDE   = 1'b1;

    // Register reset values
    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST = 11'd100;
    localparam logic [CFG_W-1:0] TILE_SIDE_RST   = 11'd10;

    // Geometry limits
    localparam logic [CFG_W-1:0]   WIDTH_MIN    = 11'd3;
    localparam logic [CFG_W-1:0]   BLOCK_LIMIT  = 11'd1024;
    localparam logic [PHASE_W-1:0] PHASE_INNER  = 10'd2;

    // Input request
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               frame_start;
    } t_pix_req;

    // Result item
    typedef struct packed {
        logic [CODE_W-1:0]  lbp_code;
        logic [COORD_W-1:0] center_row;
        logic [COORD_W-1:0] center_col;
    } t_lbp_res;

    // Per-request position information from the counter unit
    typedef struct packed {
        logic               emit;
        logic [COORD_W-1:0] center_row;
        logic [COORD_W-1:0] center_col;
    } t_pos_info;

endpackage

`default_nettype wire

>>> rtl/core/lbpe_ram.sv
// ----------------------------------------------------------------------------
// lbpe_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lbpe_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lbpe_pos.sv
// ----------------------------------------------------------------------------
// lbpe_pos
// Raster position and block phase counters; decides which centres get a code.
// ----------------------------------------------------------------------------
`default_nettype none

module lbpe_pos #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_acc,
    input  wire logic                             i_frame_start,
    input  wire logic [lbpe_pkg::CFG_W-1:0]       i_image_width,
    input  wire logic [lbpe_pkg::CFG_W-1:0]       i_tile_side,
    output logic      [$clog2(MAX_WIDTH)-1:0]     o_addr,
    output lbpe_pkg::t_pos_info                   o_info
);

    import lbpe_pkg::*;

    localparam int unsigned CW  = $clog2(MAX_WIDTH);
    localparam int unsigned RW  = $clog2(MAX_HEIGHT);
    localparam int unsigned MWW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned LW  = (MWW > CFG_W) ? MWW : CFG_W;
    localparam int unsigned CXW = (CW > COORD_W) ? CW : COORD_W;
    localparam int unsigned RXW = (RW > COORD_W) ? RW : COORD_W;

    logic [CW-1:0]      r_col_count, n_col_count;
    logic [RW-1:0]      r_row_count, n_row_count;
    logic [PHASE_W-1:0] r_col_phase, n_col_phase;
    logic [PHASE_W-1:0] r_row_phase, n_row_phase;

    logic [CW-1:0]      cc;
    logic [RW-1:0]      rc;
    logic [PHASE_W-1:0] cp;
    logic [PHASE_W-1:0] rp;
    logic [LW-1:0]      width_ext;
    logic [LW-1:0]      width_eff;
    logic [LW-1:0]      cc_ext;
    logic [CFG_W-1:0]   block_eff;
    logic               last_col;
    logic               last_row;
    logic [CXW-1:0]     ccol_m1;
    logic [RXW-1:0]     crow_m1;

    // Clamp the geometry registers to their working ranges
    always_comb begin
        width_ext = LW'(i_image_width);
        if (width_ext < LW'(WIDTH_MIN)) begin
            width_eff = LW'(WIDTH_MIN);
        end else if (width_ext > LW'(MAX_WIDTH)) begin
            width_eff = LW'(MAX_WIDTH);
        end else begin
            width_eff = width_ext;
        end
        block_eff = (i_tile_side > BLOCK_LIMIT) ? BLOCK_LIMIT : i_tile_side;
    end

    // Position of the incoming pixel, restarted by frame start
    always_comb begin
        cc = i_frame_start ? '0 : r_col_count;
        rc = i_frame_start ? '0 : r_row_count;
        cp = i_frame_start ? '0 : r_col_phase;
        rp = i_frame_start ? '0 : r_row_phase;
    end

    assign cc_ext   = LW'(cc);
    assign last_col = (cc_ext + LW'(1)) >= width_eff;
    assign last_row = ({1'b0, rc} + (RW+1)'(1)) >= (RW+1)'(MAX_HEIGHT);

    // Centre sits one row up and one column left of the incoming pixel
    assign ccol_m1 = CXW'(cc) - CXW'(1);
    assign crow_m1 = RXW'(rc) - RXW'(1);

    assign o_addr            = cc;
    assign o_info.emit       = (cp >= PHASE_INNER) && (rp >= PHASE_INNER)
                               && (cc_ext < width_eff);
    assign o_info.center_row = crow_m1[COORD_W-1:0];
    assign o_info.center_col = ccol_m1[COORD_W-1:0];

    // Advance counters and phases
    always_comb begin
        n_col_count = r_col_count;
        n_row_count = r_row_count;
        n_col_phase = r_col_phase;
        n_row_phase = r_row_phase;
        if (i_acc) begin
            if (last_col) begin
                n_col_count = '0;
                n_col_phase = '0;
                n_row_count = last_row ? '0 : rc + RW'(1);
                n_row_phase = (({1'b0, rp} + (PHASE_W+1)'(1)) >= (PHASE_W+1)'(block_eff))
                              ? '0 : rp + PHASE_W'(1);
            end else begin
                n_col_count = cc + CW'(1);
                n_row_count = rc;
                n_row_phase = rp;
                n_col_phase = (({1'b0, cp} + (PHASE_W+1)'(1)) >= (PHASE_W+1)'(block_eff))
                              ? '0 : cp + PHASE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= '0;
            r_row_count <= '0;
            r_col_phase <= '0;
            r_row_phase <= '0;
        end else begin
            r_col_count <= n_col_count;
            r_row_count <= n_row_count;
            r_col_phase <= n_col_phase;
            r_row_phase <= n_row_phase;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lbpe_code.sv
// ----------------------------------------------------------------------------
// lbpe_code
// 3x3 window registers and the eight neighbour comparisons.
// ----------------------------------------------------------------------------
`default_nettype none

module lbpe_code (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_shift,
    input  wire logic [lbpe_pkg::PIXEL_W-1:0]   i_top,
    input  wire logic [lbpe_pkg::PIXEL_W-1:0]   i_mid,
    input  wire logic [lbpe_pkg::PIXEL_W-1:0]   i_bot,
    output logic      [lbpe_pkg::CODE_W-1:0]    o_code
);

    import lbpe_pkg::*;

    // Two previous columns: top-left, top, left, centre, bottom-left, bottom
    logic [PIXEL_W-1:0] r_tl, r_t, r_l, r_c, r_bl, r_b;

    // Shift the window by one column per processed pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tl <= '0;
            r_t  <= '0;
            r_l  <= '0;
            r_c  <= '0;
            r_bl <= '0;
            r_b  <= '0;
        end else if (i_shift) begin
            r_tl <= r_t;
            r_t  <= i_top;
            r_l  <= r_c;
            r_c  <= i_mid;
            r_bl <= r_b;
            r_b  <= i_bot;
        end
    end

    // Compare each neighbour against the centre, top-left first
    assign o_code = {r_tl  >= r_c,
                     r_t   >= r_c,
                     i_top >= r_c,
                     i_mid >= r_c,
                     i_bot >= r_c,
                     r_b   >= r_c,
                     r_bl  >= r_c,
                     r_l   >= r_c};

endmodule

`default_nettype wire

>>> rtl/core/lbp_block_interior_encoder_top.sv
// Stage 1 registers the bottom-right pixel; its code is then registered to drive o_valid.
// Throughput: one pixel per cycle while o_stall is low; the line-store RAMs are read once
// and written once per pixel. A result held in the stalled output register stops the next
// pixel only while stage 1 holds a pixel that completes another code.
// Reset (synchronous, active low) clears counters, window and handshake state and
// sets image_width to 100 and the block side to 10; line stores hold no reset value.
// ----------------------------------------------------------------------------
// lbp_block_interior_encoder_top
// Streaming 3x3 local binary pattern encoder for square block interiors.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_block_interior_encoder_top #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Pixel requests
    input  wire logic                              i_valid,
    input  wire lbpe_pkg::t_pix_req                i_data,
    output logic                                   o_stall,
    // Results
    output logic                                   o_valid,
    output lbpe_pkg::t_lbp_res                     o_data,
    input  wire logic                              i_stall,
    // Configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lbpe_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [lbpe_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [lbpe_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    import lbpe_pkg::*;

    localparam int unsigned AW = $clog2(MAX_WIDTH);

    // Configuration registers
    logic [CFG_W-1:0] r_image_width;
    logic [CFG_W-1:0] r_tile_side;
    logic             cfg_wr;

    // Front end
    logic             acc;
    logic [AW-1:0]    pos_addr;
    t_pos_info        pos_info;

    // Stage 1
    logic             r_s1_valid;
    logic [PIXEL_W-1:0] r_s1_px;
    t_pos_info        r_s1_info;
    logic [AW-1:0]    r_s1_addr;
    logic             r_s1_byp;
    logic [PIXEL_W-1:0] r_s1_byp_top;
    logic [PIXEL_W-1:0] r_s1_byp_mid;
    logic [PIXEL_W-1:0] older_rdata;
    logic [PIXEL_W-1:0] newer_rdata;
    logic [PIXEL_W-1:0] s1_top;
    logic [PIXEL_W-1:0] s1_mid;
    logic [CODE_W-1:0]  s1_code;
    logic             s1_adv;

    // Output register
    logic             r_o_valid;
    t_lbp_res         r_o_data;

    // Register write and read-back
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= IMAGE_WIDTH_RST;
            r_tile_side   <= TILE_SIDE_RST;
        end else if (cfg_wr) begin
            case (paddr[REG_SEL_BIT])
                REG_IMAGE_WIDTH: r_image_width <= pwdata[CFG_W-1:0];
                REG_TILE_SIDE:   r_tile_side   <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[REG_SEL_BIT])
            REG_IMAGE_WIDTH: prdata = APB_DATA_W'(r_image_width);
            REG_TILE_SIDE:   prdata = APB_DATA_W'(r_tile_side);
            default:         prdata = '0;
        endcase
    end

    // Handshake: stage 1 moves on unless its result finds the output full
    assign s1_adv  = r_s1_valid && (!r_s1_info.emit || !r_o_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign acc     = i_valid && !o_stall;

    // Position counters
    lbpe_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (acc),
        .i_frame_start (i_data.frame_start),
        .i_image_width (r_image_width),
        .i_tile_side   (r_tile_side),
        .o_addr        (pos_addr),
        .o_info        (pos_info)
    );

    // Line stores: read for the incoming pixel, written as stage 1 leaves
    lbpe_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_older_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_addr),
        .i_wdata (s1_mid),
        .i_re    (acc),
        .i_raddr (pos_addr),
        .o_rdata (older_rdata)
    );

    lbpe_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_newer_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_addr),
        .i_wdata (r_s1_px),
        .i_re    (acc),
        .i_raddr (pos_addr),
        .o_rdata (newer_rdata)
    );

    // Forward a same-column write that lands in the read cycle
    assign s1_top = r_s1_byp ? r_s1_byp_top : older_rdata;
    assign s1_mid = r_s1_byp ? r_s1_byp_mid : newer_rdata;

    // Stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_px      <= i_data.pixel;
            r_s1_info    <= pos_info;
            r_s1_addr    <= pos_addr;
            r_s1_byp     <= s1_adv && (r_s1_addr == pos_addr);
            r_s1_byp_top <= s1_mid;
            r_s1_byp_mid <= r_s1_px;
        end
    end

    // Window and comparisons
    lbpe_code u_code (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (s1_adv),
        .i_top   (s1_top),
        .i_mid   (s1_mid),
        .i_bot   (r_s1_px),
        .o_code  (s1_code)
    );

    // Output register: load on a new result, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv && r_s1_info.emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_info.emit) begin
            r_o_data.lbp_code   <= s1_code;
            r_o_data.center_row <= r_s1_info.center_row;
            r_o_data.center_col <= r_s1_info.center_col;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule

`default_nettype wire

>>> tb/tb_lbp_block_interior_encoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lbp_block_interior_encoder_top
// Self-checking bench for the block-interior 3x3 LBP encoder. Pixel requests
// are queued per register setting and sent with random gaps. The bench's own
// line stores and window predict each code and its centre, and the codes are
// compared in order as they come out under random output stall. Settings cover
// out-of-range widths and block sizes, register changes in mid-frame and a
// partial row at the full line width.
// ----------------------------------------------------------------------------

module tb_lbp_block_interior_encoder_top;

    import lbpe_pkg::*;

    localparam int unsigned LINE_DEPTH     = 1024;
    localparam int unsigned ROW_LIMIT      = 1024;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned END_LIMIT      = 5000;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned RANDOM_ITEMS   = 1000;
    localparam int unsigned REPORT_LIMIT   = 10;

    localparam logic [APB_ADDR_W-1:0] ADDR_IMAGE_WIDTH =
        APB_ADDR_W'(REG_IMAGE_WIDTH) << REG_SEL_BIT;
    localparam logic [APB_ADDR_W-1:0] ADDR_TILE_SIDE =
        APB_ADDR_W'(REG_TILE_SIDE) << REG_SEL_BIT;

    typedef enum {PIX_SPREAD, PIX_NARROW, PIX_BINARY} t_pix_mode;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    t_pix_req              i_data  = '0;
    logic                  o_stall;
    logic                  o_valid;
    t_lbp_res              o_data;
    logic                  i_stall = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Pending pixel requests and the codes they are due to produce
    t_pix_req    pix_q[$];
    t_lbp_res    code_q[$];
    int unsigned queued_total = 0;
    int unsigned taken_total  = 0;
    int unsigned checked_cnt  = 0;
    int unsigned bad_cnt      = 0;
    int unsigned phase_cnt    = 0;
    bit          calm         = 1'b0;

    // Encoder state as the bench sees it
    logic [CFG_W-1:0]   width_reg = IMAGE_WIDTH_RST;
    logic [CFG_W-1:0]   block_reg = TILE_SIDE_RST;
    logic [PIXEL_W-1:0] line_far  [LINE_DEPTH] = '{default: '0};
    logic [PIXEL_W-1:0] line_near [LINE_DEPTH] = '{default: '0};
    bit                 def_far   [LINE_DEPTH] = '{default: 1'b0};
    bit                 def_near  [LINE_DEPTH] = '{default: 1'b0};
    logic [PIXEL_W-1:0] win_taps  [6]          = '{default: '0};
    int unsigned        pix_col = 0;
    int unsigned        pix_row = 0;
    int unsigned        col_ph  = 0;
    int unsigned        row_ph  = 0;

    lbp_block_interior_encoder_top #(
        .MAX_WIDTH  (LINE_DEPTH),
        .MAX_HEIGHT (ROW_LIMIT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5;
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
    end

    // Clamp the width register to the usable range
    function automatic int unsigned eff_width();
        if (width_reg < WIDTH_MIN) return WIDTH_MIN;
        if (width_reg > LINE_DEPTH) return LINE_DEPTH;
        return width_reg;
    endfunction

    function automatic int unsigned eff_block();
        return (block_reg > BLOCK_LIMIT) ? BLOCK_LIMIT : block_reg;
    endfunction

    function automatic int unsigned step_phase(input int unsigned ph, input int unsigned bs);
        return (ph + 1 >= bs) ? 0 : ph + 1;
    endfunction

    // True when both line stores hold written data for every column in use
    function automatic bit lines_defined();
        int unsigned c;
        for (c = 0; c < eff_width(); c++)
            if (!def_far[c] || !def_near[c]) return 1'b0;
        return 1'b1;
    endfunction

    // Take one pixel request; queue the code whose bottom-right neighbour it is
    task automatic encode_pixel(input t_pix_req req);
        int unsigned        w;
        int unsigned        bs;
        int unsigned        col;
        logic [PIXEL_W-1:0] top;
        logic [PIXEL_W-1:0] mid;
        logic [PIXEL_W-1:0] ctr;
        t_lbp_res           res;
        w  = eff_width();
        bs = eff_block();
        if (req.frame_start) begin
            pix_col = 0;
            pix_row = 0;
            col_ph  = 0;
            row_ph  = 0;
        end
        col = pix_col % LINE_DEPTH;
        top = line_far[col];
        mid = line_near[col];
        if (col_ph >= PHASE_INNER && row_ph >= PHASE_INNER && pix_col < w) begin
            ctr = win_taps[3];
            res.lbp_code   = {win_taps[0] >= ctr, win_taps[1] >= ctr, top >= ctr, mid >= ctr,
                              req.pixel >= ctr, win_taps[5] >= ctr, win_taps[4] >= ctr,
                              win_taps[2] >= ctr};
            res.center_row = COORD_W'(pix_row - 1);
            res.center_col = COORD_W'(pix_col - 1);
            code_q.push_back(res);
        end
        def_far[col]  = def_near[col];
        def_near[col] = 1'b1;
        line_far[col]  = mid;
        line_near[col] = req.pixel;
        win_taps[0] = win_taps[1];
        win_taps[1] = top;
        win_taps[2] = win_taps[3];
        win_taps[3] = mid;
        win_taps[4] = win_taps[5];
        win_taps[5] = req.pixel;
        if (pix_col + 1 >= w) begin
            pix_col = 0;
            col_ph  = 0;
            pix_row = (pix_row + 1 >= ROW_LIMIT) ? 0 : pix_row + 1;
            row_ph  = step_phase(row_ph, bs);
        end else begin
            pix_col = pix_col + 1;
            col_ph  = step_phase(col_ph, bs);
        end
    endtask

    // Mostly single cycles, now and then a long hold
    function automatic int unsigned stretch_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 1;
        if (r < 90) return $urandom_range(2, 4);
        if (r < 98) return $urandom_range(5, 12);
        return $urandom_range(13, 40);
    endfunction

    // Driver: predict each accepted request, then present the next one
    int unsigned gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                encode_pixel(i_data);
                taken_total++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_valid  <= 1'b0;
                end else if (pix_q.size() != 0) begin
                    i_data   <= pix_q.pop_front();
                    i_valid  <= 1'b1;
                    gap_left <= (calm || $urandom_range(0, 9) < 6) ? 0 : stretch_len();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted code against the oldest prediction
    int unsigned hold_cnt = 0;
    t_lbp_res    want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall  <= 1'b0;
            hold_cnt <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (code_q.size() == 0) begin
                    bad_cnt++;
                    if (bad_cnt <= REPORT_LIMIT)
                        $display("unexpected code %h for centre (%0d,%0d)",
                                 o_data.lbp_code, o_data.center_row, o_data.center_col);
                end else begin
                    want = code_q.pop_front();
                    checked_cnt++;
                    if (o_data.lbp_code !== want.lbp_code ||
                        o_data.center_row !== want.center_row ||
                        o_data.center_col !== want.center_col) begin
                        bad_cnt++;
                        if (bad_cnt <= REPORT_LIMIT)
                            $display("code mismatch: expected %h (%0d,%0d), got %h (%0d,%0d)",
                                     want.lbp_code, want.center_row, want.center_col,
                                     o_data.lbp_code, o_data.center_row, o_data.center_col);
                    end
                end
            end
            if (hold_cnt != 0) begin
                hold_cnt <= hold_cnt - 1;
            end else if (calm || $urandom_range(0, 2) != 0) begin
                i_stall  <= 1'b0;
                hold_cnt <= $urandom_range(0, 8);
            end else begin
                i_stall  <= 1'b1;
                hold_cnt <= stretch_len();
            end
        end
    end

    // Watchdog: give up when nothing moves on either channel for too long
    int unsigned idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Register write: setup cycle, then access cycle until pready
    task automatic cfg_write(input logic [APB_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_IMAGE_WIDTH) width_reg = value;
        else block_reg = value;
    endtask

    // Wait until every request is taken and every code has come out
    task automatic settle();
        while (taken_total != queued_total || code_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_pixel(input logic [PIXEL_W-1:0] pix, input bit fs);
        t_pix_req r;
        r.pixel       = pix;
        r.frame_start = fs;
        pix_q.push_back(r);
        queued_total++;
    endtask

    // Send a 3x3 image, top-left pixel in the top byte
    task automatic push_patch(input logic [9*PIXEL_W-1:0] img);
        int i;
        for (i = 8; i >= 0; i--)
            push_pixel(img[i*PIXEL_W +: PIXEL_W], i == 8);
    endtask

    function automatic logic [PIXEL_W-1:0] random_pixel(input t_pix_mode mode);
        case (mode)
            PIX_NARROW: return PIXEL_W'($urandom_range(100, 103));
            PIX_BINARY: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            default:    return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    // One register setting: write both registers, then queue its requests.
    // Skip the frame start only where the line stores already hold data.
    task automatic run_phase(input int unsigned width, input int unsigned block,
                             input int unsigned n, input bit fresh, input bit fs_noise,
                             input t_pix_mode mode);
        int unsigned i;
        bit          fs;
        settle();
        cfg_write(ADDR_IMAGE_WIDTH, CFG_W'(width));
        cfg_write(ADDR_TILE_SIDE, CFG_W'(block));
        if (!fresh && !lines_defined()) fresh = 1'b1;
        calm = ($urandom_range(0, 3) == 0);
        for (i = 0; i < n; i++) begin
            fs = (i == 0 && fresh) || (fs_noise && $urandom_range(0, 299) == 0);
            push_pixel(random_pixel(mode), fs);
        end
        phase_cnt++;
    endtask

    function automatic int unsigned pick_width();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return $urandom_range(0, 2);
        if (r == 1) return $urandom_range(17, 48);
        return $urandom_range(3, 16);
    endfunction

    function automatic int unsigned pick_block();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 2) return $urandom_range(0, 2);
        if (r == 2) return $urandom_range(1024, 2047);
        return $urandom_range(3, 9);
    endfunction

    initial begin
        int unsigned random_items;
        int unsigned w;
        int unsigned n;
        int unsigned waited;
        t_pix_mode   mode;
        random_items = 0;
        waited       = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Tiny 3x3 images with a width below the minimum: all set, mixed with ties, none set
        settle();
        cfg_write(ADDR_IMAGE_WIDTH, CFG_W'(0));
        cfg_write(ADDR_TILE_SIDE, CFG_W'(3));
        push_patch({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        push_patch({8'd127, 8'd128, 8'd129, 8'd0, 8'd128, 8'd255, 8'd128, 8'd127, 8'd129});
        push_patch({8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});

        // Change geometry in mid-frame: shrink the width past the column counter,
        // shrink the block past the row phase, then grow the block again
        run_phase(12, 5, 58, 1'b1, 1'b0, PIX_SPREAD);
        run_phase(7, 3, 40, 1'b0, 1'b0, PIX_NARROW);
        run_phase(7, 6, 30, 1'b0, 1'b0, PIX_SPREAD);

        // Part of a full-width row, width and block registers above their limits
        run_phase(2047, 2000, 160, 1'b1, 1'b0, PIX_SPREAD);

        // Random settings, mostly small images
        while (random_items < RANDOM_ITEMS) begin
            w = pick_width();
            n = (w < WIDTH_MIN) ? WIDTH_MIN : w;
            n = n * $urandom_range(3, 7) + $urandom_range(0, n - 1);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: mode = PIX_SPREAD;
                6, 7:             mode = PIX_NARROW;
                default:          mode = PIX_BINARY;
            endcase
            run_phase(w, pick_block(), n, $urandom_range(0, 2) != 0, 1'b1, mode);
            random_items += n;
        end

        // Drain, then allow for the pipeline latency
        while ((taken_total != queued_total || code_q.size() != 0) && waited < END_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (code_q.size() != 0) begin
            $display("%0d expected codes never came out", code_q.size());
            bad_cnt += code_q.size();
        end

        $display("Sent %0d pixel requests over %0d register settings, incl. clamped widths,",
                 taken_total, phase_cnt + 1);
        $display("block sizes 0..2047 and mid-frame changes; %0d codes compared, %0d bad.",
                 checked_cnt, bad_cnt);
        if (bad_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
